// ===== rtl/core/lsra_pkg.sv =====
// ----------------------------------------------------------------------------
// lsra_pkg - shared types and constants
// Beat payloads, configuration, queue command and register indexes for the
// literal stream replace-all core.
// ----------------------------------------------------------------------------
package lsra_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACE_MAX_DEF = 8;

  localparam int LEN_W   = 4;   // length registers and beat counts
  localparam int POS_W   = 3;   // byte position within a 64-bit word
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // configuration register indexes
  localparam logic [1:0] REG_PATTERN_BYTES     = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH    = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_beat_t;

  typedef struct packed {
    logic [63:0]      pattern_bytes;
    logic [LEN_W-1:0] pattern_length;
    logic [63:0]      replacement_bytes;
    logic [LEN_W-1:0] replacement_length;
  } cfg_t;

  // One queued job: emit len beats. repl selects the replacement word;
  // otherwise beat i is pattern byte i for i < pos and the item byte at pos.
  typedef struct packed {
    logic             repl;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/literal_stream_replace_all_core.sv =====
// ----------------------------------------------------------------------------
// literal_stream_replace_all_core - streaming literal replace-all
// Replaces every leftmost, non-overlapping occurrence of a pattern of up to
// PATTERN_MAX bytes by a replacement of up to REPLACE_MAX bytes.
// ----------------------------------------------------------------------------
// The core takes one input byte per cycle unless the job queue is full and
// gives one output beat per cycle unless the output stalls. The front end
// matches each byte combinationally and queues an emit job (the bytes that
// can no longer start a match, the replacement, or the final flush); a
// four-entry job queue feeds the back end, which walks each job one beat per
// unstalled clock into the output register. A plain byte gives one beat, a
// byte that extends a partial match none, a completed match one beat per
// replacement byte and a flush at a mismatch or at the end of a string one
// beat per flushed byte, so input stall rises only when the queue fills
// behind such bursts. Pending bytes are always a prefix of the pattern, so
// only their count is held. A zero pattern or replacement length passes
// bytes through; lengths above the maximum saturate. Any configuration write
// drops the pending bytes; write only while idle.
// ----------------------------------------------------------------------------
module literal_stream_replace_all_core #(
  parameter int PATTERN_MAX = lsra_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = lsra_pkg::REPLACE_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  // input stream
  input  logic                in_valid,
  output logic                in_stall,
  input  lsra_pkg::in_beat_t  in_data,
  // output stream
  output logic                out_valid,
  input  logic                out_stall,
  output lsra_pkg::out_beat_t out_data
);

  lsra_pkg::cfg_t      cfg;
  lsra_pkg::cmd_t      q_wr;
  lsra_pkg::cmd_t      q_head;
  lsra_pkg::q_status_t q_stat;
  logic                accept;
  logic                push;
  logic                pop;

  // Register file; no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lsra_pkg::REG_PATTERN_BYTES:      cfg.pattern_bytes      <= cfg_data;
        lsra_pkg::REG_PATTERN_LENGTH:     cfg.pattern_length     <= cfg_data[3:0];
        lsra_pkg::REG_REPLACEMENT_BYTES:  cfg.replacement_bytes  <= cfg_data;
        lsra_pkg::REG_REPLACEMENT_LENGTH: cfg.replacement_length <= cfg_data[3:0];
        default:                          cfg <= cfg;
      endcase
    end
  end

  // Input waits only on queue room, never on the output side directly.
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  lsra_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cfg_we (cfg_we),
    .accept (accept),
    .beat   (in_data),
    .push   (push),
    .cmd    (q_wr)
  );

  lsra_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (q_wr),
    .pop    (pop),
    .head   (q_head),
    .status (q_stat)
  );

  lsra_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (q_head),
    .head_valid (!q_stat.empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // queue never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job queue overflow");

  // queue never popped when empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("job queue underflow");

  // a job always carries at least one beat
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_wr.len != '0))
    else $error("empty job queued");

  // nothing leaves the core right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat right after reset");

endmodule

// ===== rtl/core/lsra_front.sv =====
// ----------------------------------------------------------------------------
// lsra_front - matcher front end
// Tracks how much of the pattern is pending, finds the smallest drop on each
// byte and turns the item into at most one queued emit job.
// ----------------------------------------------------------------------------
module lsra_front #(
  parameter int PATTERN_MAX = lsra_pkg::PATTERN_MAX_DEF,
  parameter int REPLACE_MAX = lsra_pkg::REPLACE_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lsra_pkg::cfg_t     cfg,
  input  logic               cfg_we,
  input  logic               accept,
  input  lsra_pkg::in_beat_t beat,
  output logic               push,
  output lsra_pkg::cmd_t     cmd
);

  localparam int LW = lsra_pkg::LEN_W;
  localparam int PW = lsra_pkg::POS_W;

  // Pending bytes always equal the pattern prefix of length count, so only
  // the count is kept.
  logic [PW-1:0] count;
  logic [PW-1:0] count_next;

  logic [LW-1:0] p_eff;
  logic [LW-1:0] r_eff;
  logic          pass;
  logic [PW-1:0] c;
  logic [LW-1:0] cnt1;
  logic [LW-1:0] s;
  logic [7:0]    pat_b [0:7];
  logic          ov    [0:PATTERN_MAX-1][0:PATTERN_MAX-1];
  logic          hit   [0:PATTERN_MAX-1];

  assign p_eff = (cfg.pattern_length > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX)
                                                         : cfg.pattern_length;
  assign r_eff = (cfg.replacement_length > LW'(REPLACE_MAX)) ? LW'(REPLACE_MAX)
                                                             : cfg.replacement_length;
  assign pass  = (p_eff == '0) || (r_eff == '0);
  assign c     = ({1'b0, count} >= p_eff) ? '0 : count;
  assign cnt1  = LW'({1'b0, c}) + LW'(1);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pat_b[i] = cfg.pattern_bytes[8*i +: 8];
    end
  end

  // Self-overlap table: ov[cc][ss] when pattern[ss..cc-1] == pattern[0..cc-ss-1].
  always_comb begin
    for (int cc = 0; cc < PATTERN_MAX; cc++) begin
      for (int ss = 0; ss < PATTERN_MAX; ss++) begin
        ov[cc][ss] = (ss <= cc);
        for (int i = 0; i < PATTERN_MAX; i++) begin
          if ((ss <= cc) && (i < cc - ss) &&
              (pat_b[PW'(ss + i)] != pat_b[PW'(i)])) begin
            ov[cc][ss] = 1'b0;
          end
        end
      end
    end
  end

  // Drop ss works when the overlap holds and the new byte continues it.
  always_comb begin
    for (int ss = 0; ss < PATTERN_MAX; ss++) begin
      hit[ss] = (ss <= int'(c)) && ov[c][ss] &&
                (beat.in_byte == pat_b[PW'(int'(c) - ss)]);
    end
    s = cnt1;
    for (int ss = PATTERN_MAX - 1; ss >= 0; ss--) begin
      if (hit[ss]) begin
        s = LW'(ss);
      end
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.data   = beat.in_byte;
    cmd.last   = beat.in_last;
    push       = 1'b0;
    count_next = count;
    if (cfg_we) begin
      count_next = '0;
    end else if (accept) begin
      if (pass) begin
        cmd.len    = LW'(1);
        push       = 1'b1;
        count_next = '0;
      end else if ((s == '0) && (cnt1 == p_eff)) begin
        cmd.repl   = 1'b1;
        cmd.len    = r_eff;
        push       = 1'b1;
        count_next = '0;
      end else begin
        cmd.pos    = c;
        cmd.len    = beat.in_last ? cnt1 : s;
        push       = beat.in_last || (s != '0);
        count_next = beat.in_last ? '0 : PW'(cnt1 - s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ===== rtl/core/lsra_queue.sv =====
// ----------------------------------------------------------------------------
// lsra_queue - job queue
// Small first-in first-out store of emit jobs between front and back.
// ----------------------------------------------------------------------------
module lsra_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lsra_pkg::cmd_t      wr_cmd,
  input  logic                pop,
  output lsra_pkg::cmd_t      head,
  output lsra_pkg::q_status_t status
);

  lsra_pkg::cmd_t                     slots [0:lsra_pkg::QDEPTH-1];
  logic [lsra_pkg::QPTR_W-1:0]        wr_ptr;
  logic [lsra_pkg::QPTR_W-1:0]        rd_ptr;
  logic [lsra_pkg::QCNT_W-1:0]        fill;

  assign head         = slots[rd_ptr];
  assign status.full  = (fill == lsra_pkg::QCNT_W'(lsra_pkg::QDEPTH));
  assign status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/lsra_back.sv =====
// ----------------------------------------------------------------------------
// lsra_back - beat sequencer
// Walks the head job one beat per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module lsra_back (
  input  logic                clk,
  input  logic                rst,
  input  lsra_pkg::cfg_t      cfg,
  input  lsra_pkg::cmd_t      head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lsra_pkg::out_beat_t out_data
);

  localparam int LW = lsra_pkg::LEN_W;
  localparam int PW = lsra_pkg::POS_W;

  logic [PW-1:0] idx;
  logic          load;
  logic          emit;
  logic          last_beat;
  logic [7:0]    sel_byte;

  assign load      = !out_valid || !out_stall;
  assign emit      = load && head_valid;
  assign last_beat = ({1'b0, idx} == (head.len - LW'(1)));
  assign pop       = emit && last_beat;

  always_comb begin
    if (head.repl) begin
      sel_byte = cfg.replacement_bytes[{idx, 3'b000} +: 8];
    end else if (idx == head.pos) begin
      sel_byte = head.data;
    end else begin
      sel_byte = cfg.pattern_bytes[{idx, 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= last_beat ? '0 : idx + 1'b1;
      end else if (load) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_byte <= sel_byte;
      out_data.out_last <= head.last && last_beat;
    end
  end

endmodule
